// File: hdl/ste_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sinusoidal timestep embedding package
// Shared constants, the pair descriptor word and the constant tables.
// ----------------------------------------------------------------------------
package ste_pkg;

   // Largest number of pairs per timestep and CORDIC iteration count.
   localparam logic [6:0] HALF_MAX     = 7'd64;
   localparam logic [4:0] CORDIC_STEPS = 5'd16;

   // Fixed-point constants.
   localparam logic [19:0] LOG2_10000_Q16 = 20'd870824;
   localparam logic [29:0] LN2_Q30        = 30'd744261118;
   localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
   localparam logic [51:0] TWO_PI_Q49     = 52'hC90FDAA22168C;
   localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
   localparam logic signed [19:0] Q15_MAX     = 20'sd32767;
   localparam logic signed [19:0] Q15_MIN     = -20'sd32767;

   // Horner terms of the fractional power of two, and top bit of the phase reduction.
   localparam logic [3:0] HORNER_TERMS = 4'd12;
   localparam logic [3:0] MOD_TOP_BIT  = 4'd8;

   // Depth of the descriptor queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // One pair of work handed from the front to the back.
   typedef struct packed {
      logic [23:0] timestep;
      logic [19:0] expo;
      logic [5:0]  pair_index;
      logic        last_pair;
   } desc_type;

   // Arctangent of 2^-k in Q30, truncated.
   function automatic logic [29:0] atan_q30(input logic [4:0] k);
      logic [29:0] v;
      case (k)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

   // Reciprocal floor(2^32 / k) for the Horner divisors; the result is
   // at most one low, which a remainder check repairs.
   function automatic logic [31:0] recip_q32(input logic [3:0] k);
      logic [31:0] v;
      case (k)
         4'd1:  v = 32'hFFFFFFFF;
         4'd2:  v = 32'h80000000;
         4'd3:  v = 32'h55555555;
         4'd4:  v = 32'h40000000;
         4'd5:  v = 32'h33333333;
         4'd6:  v = 32'h2AAAAAAA;
         4'd7:  v = 32'h24924924;
         4'd8:  v = 32'h20000000;
         4'd9:  v = 32'h1C71C71C;
         4'd10: v = 32'h19999999;
         4'd11: v = 32'h1745D174;
         4'd12: v = 32'h15555555;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   // Two pi in Q49 shifted left by b, for restoring reduction.
   function automatic logic [59:0] two_pi_shifted(input logic [3:0] b);
      logic [59:0] v;
      v = {8'd0, TWO_PI_Q49} << b;
      return v;
   endfunction

endpackage

// File: hdl/ste_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor queue
// Short first-in first-out queue of pair descriptors between front and back.
// ----------------------------------------------------------------------------
module ste_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ste_pkg::desc_type wr_word,
   input  logic              pop,
   output ste_pkg::desc_type rd_word,
   output logic              full,
   output logic              empty
);
   import ste_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   desc_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   assign full    = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_word = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

// File: hdl/ste_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Embedding front end
// Holds the half-width register, takes timesteps, divides the log2 constant
// by the half width once per run and emits one descriptor per pair.
// ----------------------------------------------------------------------------
module ste_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [23:0]       req_timestep,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [6:0]        csr_embedding_half,
   output logic              push,
   output ste_pkg::desc_type push_word,
   input  logic              full
);
   import ste_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_GEN  = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [6:0]  half_reg_ff;
   logic [6:0]  half_eff;
   logic [6:0]  half_ff;
   logic [23:0] time_ff;
   logic [4:0]  bit_ff, bit_in;
   logic [6:0]  rem_ff, rem_in;
   logic [19:0] quot_ff, quot_in;
   logic [19:0] expo_ff, expo_in;
   logic [6:0]  frac_ff, frac_in;
   logic [5:0]  idx_ff, idx_in;
   logic [7:0]  trial;
   logic        trial_ge;
   logic [7:0]  frac_sum;
   logic        frac_carry;
   logic        is_last;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != F_IDLE);
   assign half_eff  = (half_reg_ff > HALF_MAX) ? HALF_MAX : half_reg_ff;

   // Restoring division step: one quotient bit per cycle.
   assign trial    = {rem_ff, LOG2_10000_Q16[bit_ff]};
   assign trial_ge = (trial >= {1'b0, half_ff});

   // Running remainder of the per-index step.
   assign frac_sum   = {1'b0, frac_ff} + {1'b0, rem_ff};
   assign frac_carry = (frac_sum >= {1'b0, half_ff});
   assign is_last    = ({1'b0, idx_ff} == (half_ff - 7'd1));

   assign push = (state_ff == F_GEN) && !full;
   always_comb begin
      push_word.timestep   = time_ff;
      push_word.expo       = expo_ff;
      push_word.pair_index = idx_ff;
      push_word.last_pair  = is_last;
   end

   // Sequencing of the division and the descriptor stream.
   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      expo_in  = expo_ff;
      frac_in  = frac_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start && (half_eff != 7'd0)) begin
               state_in = F_DIV;
               bit_in   = 5'd19;
               rem_in   = '0;
               quot_in  = '0;
            end
         end
         F_DIV: begin
            rem_in  = trial_ge ? 7'(trial - {1'b0, half_ff}) : trial[6:0];
            quot_in = {quot_ff[18:0], trial_ge};
            bit_in  = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               state_in = F_GEN;
               expo_in  = '0;
               frac_in  = '0;
               idx_in   = '0;
            end
         end
         F_GEN: begin
            if (!full) begin
               idx_in  = idx_ff + 6'd1;
               expo_in = expo_ff + quot_ff + {19'd0, frac_carry};
               frac_in = frac_carry ? 7'(frac_sum - {1'b0, half_ff}) : frac_sum[6:0];
               if (is_last) begin
                  state_in = F_IDLE;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         half_reg_ff <= 7'd64;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            half_reg_ff <= csr_embedding_half;
         end
      end
   end

   // Working registers of the run.
   always_ff @(posedge clock) begin
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      expo_ff <= expo_in;
      frac_ff <= frac_in;
      idx_ff  <= idx_in;
      if ((state_ff == F_IDLE) && start) begin
         half_ff <= half_eff;
         time_ff <= req_timestep;
      end
   end

endmodule

// File: hdl/ste_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Embedding back end
// Turns one descriptor into a cosine and sine pair: fractional power of two
// by Horner, phase multiply, reduction modulo two pi, fold and CORDIC.
// ----------------------------------------------------------------------------
module ste_back (
   input  logic              clock,
   input  logic              reset,
   input  ste_pkg::desc_type head_word,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   output logic [5:0]        rsp_pair_index,
   output logic signed [15:0] rsp_cos_value,
   output logic signed [15:0] rsp_sin_value,
   output logic              rsp_last_pair
);
   import ste_pkg::*;

   typedef enum logic [11:0] {
      B_IDLE  = 12'b0000_0000_0001,
      B_YMUL  = 12'b0000_0000_0010,
      B_YSAVE = 12'b0000_0000_0100,
      B_HMUL  = 12'b0000_0000_1000,
      B_HDIV  = 12'b0000_0001_0000,
      B_HFIX  = 12'b0000_0010_0000,
      B_PMUL  = 12'b0000_0100_0000,
      B_PSH   = 12'b0000_1000_0000,
      B_MOD   = 12'b0001_0000_0000,
      B_FOLD  = 12'b0010_0000_0000,
      B_CORD  = 12'b0100_0000_0000,
      B_OUT   = 12'b1000_0000_0000
   } back_state_type;

   back_state_type state_ff, state_in;
   desc_type    desc_ff;
   logic [63:0] prod_ff;
   logic [29:0] y_ff;
   logic [30:0] p_ff;
   logic [30:0] v_ff;
   logic [3:0]  k_ff;
   logic [59:0] r_ff;
   logic [3:0]  b_ff;
   logic signed [33:0] x_ff;
   logic signed [33:0] yc_ff;
   logic signed [32:0] z_ff;
   logic        neg_ff;
   logic [4:0]  step_ff;
   logic        rsp_valid_ff;
   logic [5:0]  rsp_index_ff;
   logic signed [15:0] rsp_cos_ff;
   logic signed [15:0] rsp_sin_ff;
   logic        rsp_last_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [30:0] q_est;
   logic [34:0] q_k;
   logic [34:0] rem;
   logic [30:0] q_fix;
   logic [59:0] ph;
   logic [59:0] modv;
   logic [52:0] round_sum;
   logic signed [34:0] a0, a1, a2;
   logic        fold_neg;
   logic signed [33:0] dx, dy;
   logic signed [32:0] atan_s;
   logic signed [33:0] xo, yo;
   logic signed [34:0] xw, yw;
   logic signed [19:0] xs, ys;
   logic signed [15:0] cos_q, sin_q;

   assign pop = (state_ff == B_IDLE) && !empty;

   // Shared multiplier, operands chosen by the sequencer.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         B_YMUL: begin
            mul_a = {16'd0, desc_ff.expo[15:0]};
            mul_b = {2'd0, LN2_Q30};
         end
         B_HMUL: begin
            mul_a = {2'd0, y_ff};
            mul_b = {1'b0, p_ff};
         end
         B_HDIV: begin
            mul_a = {1'b0, prod_ff[60:30]};
            mul_b = recip_q32(k_ff);
         end
         B_PMUL: begin
            mul_a = {8'd0, desc_ff.timestep};
            mul_b = {1'b0, p_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Quotient repair after the reciprocal multiply.
   assign q_est = prod_ff[62:32];
   assign q_k   = q_est * k_ff;
   assign rem   = {4'd0, v_ff} - q_k;
   assign q_fix = (rem >= {31'd0, k_ff}) ? (q_est + 31'd1) : q_est;

   // Phase alignment and reduction step.
   assign ph   = {prod_ff[54:0], 5'd0} >> desc_ff.expo[19:16];
   assign modv = two_pi_shifted(b_ff);

   // Rounding to Q30, wrap into minus pi to pi and fold to the right half plane.
   assign round_sum = {1'b0, r_ff[51:0]} + 53'h40000;
   assign a0 = $signed({1'b0, round_sum[52:19]});
   assign a1 = (a0 > PI_Q30) ? (a0 - TWO_PI_Q30) : a0;
   always_comb begin
      a2       = a1;
      fold_neg = 1'b0;
      if (a1 > HALF_PI_Q30) begin
         a2       = a1 - PI_Q30;
         fold_neg = 1'b1;
      end else if (a1 < -HALF_PI_Q30) begin
         a2       = a1 + PI_Q30;
         fold_neg = 1'b1;
      end
   end

   // CORDIC rotation step.
   assign dx     = yc_ff >>> step_ff;
   assign dy     = x_ff >>> step_ff;
   assign atan_s = $signed({3'd0, atan_q30(step_ff)});

   // Sign restore, rounding to Q1.15 and saturation.
   assign xo = neg_ff ? -x_ff : x_ff;
   assign yo = neg_ff ? -yc_ff : yc_ff;
   assign xw = {xo[33], xo} + 35'sd16384;
   assign yw = {yo[33], yo} + 35'sd16384;
   assign xs = 20'(xw >>> 15);
   assign ys = 20'(yw >>> 15);
   assign cos_q = (xs > Q15_MAX) ? Q15_MAX[15:0] : ((xs < Q15_MIN) ? Q15_MIN[15:0] : xs[15:0]);
   assign sin_q = (ys > Q15_MAX) ? Q15_MAX[15:0] : ((ys < Q15_MIN) ? Q15_MIN[15:0] : ys[15:0]);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (!empty) begin
                     state_in = B_YMUL;
                  end
         B_YMUL:  state_in = B_YSAVE;
         B_YSAVE: state_in = B_HMUL;
         B_HMUL:  state_in = B_HDIV;
         B_HDIV:  state_in = B_HFIX;
         B_HFIX:  state_in = (k_ff == 4'd1) ? B_PMUL : B_HMUL;
         B_PMUL:  state_in = B_PSH;
         B_PSH:   state_in = B_MOD;
         B_MOD:   if (b_ff == 4'd0) begin
                     state_in = B_FOLD;
                  end
         B_FOLD:  state_in = B_CORD;
         B_CORD:  if (step_ff == CORDIC_STEPS - 5'd1) begin
                     state_in = B_OUT;
                  end
         B_OUT:   state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == B_OUT);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (pop) begin
         desc_ff <= head_word;
      end
      case (state_ff)
         B_YSAVE: begin
            y_ff <= prod_ff[45:16];
            p_ff <= ONE_Q30;
            k_ff <= HORNER_TERMS;
         end
         B_HDIV: begin
            v_ff <= prod_ff[60:30];
         end
         B_HFIX: begin
            p_ff <= ONE_Q30 - q_fix;
            k_ff <= k_ff - 4'd1;
         end
         B_PSH: begin
            r_ff <= ph;
            b_ff <= MOD_TOP_BIT;
         end
         B_MOD: begin
            if (r_ff >= modv) begin
               r_ff <= r_ff - modv;
            end
            b_ff <= b_ff - 4'd1;
         end
         // The reduced phase is final here; fold it and seed the rotation.
         B_FOLD: begin
            z_ff    <= a2[32:0];
            neg_ff  <= fold_neg;
            x_ff    <= CORDIC_GAIN;
            yc_ff   <= '0;
            step_ff <= '0;
         end
         B_CORD: begin
            if (!z_ff[32]) begin
               x_ff  <= x_ff - dx;
               yc_ff <= yc_ff + dy;
               z_ff  <= z_ff - atan_s;
            end else begin
               x_ff  <= x_ff + dx;
               yc_ff <= yc_ff - dy;
               z_ff  <= z_ff + atan_s;
            end
            step_ff <= step_ff + 5'd1;
         end
         B_OUT: begin
            rsp_index_ff <= desc_ff.pair_index;
            rsp_cos_ff   <= cos_q;
            rsp_sin_ff   <= sin_q;
            rsp_last_ff  <= desc_ff.last_pair;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_index = rsp_index_ff;
   assign rsp_cos_value  = rsp_cos_ff;
   assign rsp_sin_value  = rsp_sin_ff;
   assign rsp_last_pair  = rsp_last_ff;

endmodule

// File: hdl/sinusoidal_timestep_embedding_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sinusoidal timestep embedding unit
// A timestep is taken when start is high and busy is low. The unit then
// emits one word per frequency index, from 0 up to the half width minus one,
// each carrying the index, the cosine and the sine in Q1.15, with the last
// word of the run marked. A word stands on the rsp_ ports for exactly one
// cycle with rsp_valid high; the receiver must take it then. The time each
// word takes is set by the CORDIC's 16 iterations, by the back end's single
// shared multiplier, which takes each of the twelve Horner terms of the
// fractional power of two through B_HMUL, B_HDIV and B_HFIX, and by the
// nine-step phase reduction. Each run opens with a divide in the front end.
// busy falls once all words of a run are queued, so the next timestep can
// be taken while the last few words are still being computed. The user must
// write the half-width register, reset to 64, through the csr_ channel only
// while the unit is idle; the block itself does not enforce it. Values above
// 64 act as 64 and zero produces no words.
// ----------------------------------------------------------------------------
module sinusoidal_timestep_embedding_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [23:0]        req_timestep,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_embedding_half,
   output logic               rsp_valid,
   output logic [5:0]         rsp_pair_index,
   output logic signed [15:0] rsp_cos_value,
   output logic signed [15:0] rsp_sin_value,
   output logic               rsp_last_pair
);
   import ste_pkg::*;

   desc_type push_word;
   desc_type head_word;
   logic     push;
   logic     pop;
   logic     full;
   logic     empty;

   // Front: register, divide and descriptor stream.
   ste_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_timestep       (req_timestep),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_embedding_half (csr_embedding_half),
      .push               (push),
      .push_word          (push_word),
      .full               (full)
   );

   // Queue between the two halves.
   ste_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_word (push_word),
      .pop     (pop),
      .rd_word (head_word),
      .full    (full),
      .empty   (empty)
   );

   // Back: per-pair arithmetic and result register.
   ste_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_word      (head_word),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_pair_index (rsp_pair_index),
      .rsp_cos_value  (rsp_cos_value),
      .rsp_sin_value  (rsp_sin_value),
      .rsp_last_pair  (rsp_last_pair)
   );

endmodule
